// File: rtl/core/facr_pkg.sv
// Shared types, constants and helpers for the fully associative read cache.
// No dependencies; every other file in rtl/core refers to this package.
package facr_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int ADDRESS_BITS = 8;
  localparam int WORD_BITS    = 17;
  localparam int VICTIM_BITS  = 4;
  localparam int LFSR_BITS    = 16;
  localparam int COUNT_BITS   = 16;

  localparam logic [LFSR_BITS-1:0]  LFSR_TOGGLE = 16'hB400;
  localparam logic [LFSR_BITS-1:0]  LFSR_SEED_RST = 16'h0001;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] address;
    logic [WORD_BITS-1:0]    fill_data;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]   read_data;
    logic                   hit;
    logic [VICTIM_BITS-1:0] victim_entry;
    logic [COUNT_BITS-1:0]  hit_total;
    logic [COUNT_BITS-1:0]  miss_total;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic fill;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
  } dp_status_t;

  // Galois LFSR, x^16+x^14+x^13+x^11+1, right shift
  function automatic logic [LFSR_BITS-1:0] lfsr_next(input logic [LFSR_BITS-1:0] s);
    logic [LFSR_BITS-1:0] n;
    n = {1'b0, s[LFSR_BITS-1:1]};
    if (s[0]) begin
      n = n ^ LFSR_TOGGLE;
    end
    return n;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

// File: rtl/core/facr_ctrl.sv
// Sequencing state machine for the fully associative read cache.
// Depends on facr_pkg for the command and status structs.
module facr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  facr_pkg::dp_status_t  status,
  output facr_pkg::dp_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = status.hit ? S_OUT : S_FILL;
      end
      S_FILL: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.lookup = (state == S_LOOK);
  assign cmd.fill   = (state == S_FILL);

endmodule

// File: rtl/core/facr_dp.sv
// Datapath of the fully associative read cache: tags, valid bits, word store,
// replacement LFSR, victim pick and hit/miss counters.
// Depends on facr_pkg; driven by facr_ctrl through dp_cmd_t.
module facr_dp #(
  parameter int ENTRIES = facr_pkg::ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [facr_pkg::LFSR_BITS-1:0]     cfg_wr_data,
  input  facr_pkg::in_beat_t                 in_data,
  input  facr_pkg::dp_cmd_t                  cmd,
  output facr_pkg::dp_status_t               status,
  output facr_pkg::out_beat_t                out_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int AW    = facr_pkg::ADDRESS_BITS;
  localparam int WW    = facr_pkg::WORD_BITS;
  localparam int LW    = facr_pkg::LFSR_BITS;
  localparam int CW    = facr_pkg::COUNT_BITS;

  logic [ENTRIES-1:0] entry_valid;
  logic [AW-1:0]      entry_tag [ENTRIES];
  logic [WW-1:0]      entry_word [ENTRIES];

  logic [LW-1:0]      lfsr;
  logic [IDX_W-1:0]   victim;

  logic [AW-1:0]      addr_q;
  logic [WW-1:0]      fill_q;
  logic [WW-1:0]      rd_q;
  logic               hit_q;
  logic [IDX_W-1:0]   idx_q;
  logic [CW-1:0]      hit_cnt;
  logic [CW-1:0]      miss_cnt;

  logic [ENTRIES-1:0] match;
  logic [IDX_W-1:0]   match_idx;
  logic [31:0]        idx_wide;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_tag[i] == addr_q);
    end
  end

  // lowest matching entry wins
  always_comb begin
    match_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = IDX_W'(i);
      end
    end
  end

  assign status.hit = |match;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr        <= facr_pkg::LFSR_SEED_RST;
      entry_valid <= '0;
      hit_cnt     <= '0;
      miss_cnt    <= '0;
    end else begin
      if (cfg_wr_en) begin
        lfsr <= (cfg_wr_data == '0) ? facr_pkg::LFSR_SEED_RST : cfg_wr_data;
      end else if (cmd.load) begin
        lfsr <= facr_pkg::lfsr_next(lfsr);
      end
      if (cmd.lookup && status.hit) begin
        hit_cnt <= facr_pkg::sat_inc(hit_cnt);
      end
      if (cmd.fill) begin
        entry_valid[victim] <= 1'b1;
        miss_cnt            <= facr_pkg::sat_inc(miss_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= in_data.address;
      fill_q <= in_data.fill_data;
      // take the victim from the low bits of the value before it advances
      victim <= lfsr[IDX_W-1:0];
    end
    if (cmd.lookup) begin
      hit_q <= status.hit;
      idx_q <= match_idx;
      rd_q  <= entry_word[match_idx];
    end
    if (cmd.fill) begin
      entry_tag[victim]  <= addr_q;
      entry_word[victim] <= fill_q;
      idx_q              <= victim;
    end
  end

  assign idx_wide = 32'(idx_q);

  assign out_data.read_data    = hit_q ? rd_q : fill_q;
  assign out_data.hit          = hit_q;
  assign out_data.victim_entry = idx_wide[facr_pkg::VICTIM_BITS-1:0];
  assign out_data.hit_total    = hit_cnt;
  assign out_data.miss_total   = miss_cnt;

endmodule

// File: rtl/core/fully_assoc_random_cache_read.sv
// Fully associative read cache, one word per entry, random replacement.
// A read is taken when in_valid is high and in_stall low; its result is held
// on out_data until taken with out_stall low, and the next read is taken in
// the cycle after that. A hit goes through accept, tag compare with the word
// store read, and result; a miss goes through accept, tag compare, fill of the
// victim entry and result. The result step lasts for as long as out_stall
// holds the result. The victim is the random value before it advances,
// modulo ENTRIES, taken as its low bits, so ENTRIES must be a power of two.
// Writing cfg_wr_data loads the replacement LFSR at once (zero is taken as 1).
// No clearing pass after reset.
module fully_assoc_random_cache_read #(
  parameter int ENTRIES = facr_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [facr_pkg::LFSR_BITS-1:0] cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  facr_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output facr_pkg::out_beat_t            out_data
);

  facr_pkg::dp_cmd_t    cmd;
  facr_pkg::dp_status_t status;

  facr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  facr_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .status      (status),
    .out_data    (out_data)
  );

endmodule
